// File: src/ikcs_pkg.sv
// shared types, constants and helpers for the kcs bmc-side engine
// no dependencies; imported by the engine and the top level

package ikcs_pkg;

  // buffer depths and derived widths
  localparam int unsigned ReqDepth  = 64;
  localparam int unsigned RespDepth = 64;
  localparam int unsigned ReqAw     = $clog2(ReqDepth);
  localparam int unsigned ReqCw     = $clog2(ReqDepth + 1);
  localparam int unsigned RespAw    = $clog2(RespDepth);
  localparam int unsigned RespCw    = $clog2(RespDepth + 1);

  localparam logic [ReqCw-1:0]  ReqFull  = ReqCw'(ReqDepth);
  localparam logic [RespCw-1:0] RespFull = RespCw'(RespDepth);

  // input word opcodes
  localparam logic [1:0] OpCmd     = 2'd0;
  localparam logic [1:0] OpData    = 2'd1;
  localparam logic [1:0] OpHandler = 2'd2;

  // status state bits
  localparam logic [1:0] KsIdle  = 2'd0;
  localparam logic [1:0] KsRead  = 2'd1;
  localparam logic [1:0] KsWrite = 2'd2;
  localparam logic [1:0] KsError = 2'd3;

  // error codes
  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrAborted = 2'd1;
  localparam logic [1:0] ErrIllegal = 2'd2;
  localparam logic [1:0] ErrLength  = 2'd3;

  // host control codes
  localparam logic [7:0] CcAbort  = 8'h60;
  localparam logic [7:0] CcWstart = 8'h61;
  localparam logic [7:0] CcWend   = 8'h62;
  localparam logic [7:0] CcRead   = 8'h68;

  // completion codes and response header bits
  localparam logic [7:0] CompBadLun   = 8'hC2;
  localparam logic [7:0] CompBadLen   = 8'hC4;
  localparam logic [7:0] CompOverflow = 8'hFF;
  localparam logic [7:0] NetfnRespBit = 8'h04;
  localparam logic [1:0] LunMask      = 2'b11;

  // fixed response buffer slots
  localparam logic [RespAw-1:0] RespCmdSlot  = RespAw'(1);
  localparam logic [RespAw-1:0] RespCompSlot = RespAw'(2);

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       resp_last;
  } in_item_t;

  typedef struct packed {
    logic       odr_valid;
    logic [7:0] odr_byte;
    logic [1:0] status_state;
    logic [1:0] error_code;
    logic       req_valid;
    logic [7:0] req_byte;
    logic       last;
  } out_item_t;

  // status byte given on the first abort read
  function automatic logic [7:0] abort_status(input logic [1:0] err);
    logic [7:0] code;
    code = 8'h00;
    unique case (err)
      ErrNone:    code = 8'h00;
      ErrAborted: code = 8'h01;
      ErrIllegal: code = 8'h02;
      ErrLength:  code = 8'h06;
      default:    code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

// File: src/ikcs_ram.sv
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies; used for the request and response buffers

module ikcs_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 8,
  localparam int unsigned Aw = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: src/ikcs_engine.sv
// kcs protocol sequencer: phase state, counters and the result register
// depends on ikcs_pkg; drives the two buffer rams in the top level

module ikcs_engine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  ikcs_pkg::in_item_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output ikcs_pkg::out_item_t       out_data_o,
  output logic                      req_we_o,
  output logic [ikcs_pkg::ReqAw-1:0] req_waddr_o,
  output logic [7:0]                req_wdata_o,
  output logic                      req_re_o,
  output logic [ikcs_pkg::ReqAw-1:0] req_raddr_o,
  input  logic [7:0]                req_rdata_i,
  output logic                      resp_we_o,
  output logic [ikcs_pkg::RespAw-1:0] resp_waddr_o,
  output logic [7:0]                resp_wdata_o,
  output logic                      resp_re_o,
  output logic [ikcs_pkg::RespAw-1:0] resp_raddr_o,
  input  logic [7:0]                resp_rdata_i
);

  import ikcs_pkg::*;

  typedef enum logic [2:0] {
    S_WAIT,
    S_EXEC,
    S_HDR1,
    S_HDR2,
    S_RUN,
    S_RDOUT
  } fsm_e;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_WSTART,
    PH_WDATA,
    PH_WEND,
    PH_RWAIT,
    PH_READ,
    PH_ABORT1,
    PH_ABORT2,
    PH_ERROR
  } phase_e;

  fsm_e              fsm_q, fsm_d;
  phase_e            ph_q, ph_d;
  logic [1:0]        kst_q, kst_d;
  logic [1:0]        err_q, err_d;
  logic [ReqCw-1:0]  cnt_q, cnt_d;
  logic [ReqCw-1:0]  run_q, run_d;
  logic [RespCw-1:0] idx_q, idx_d;
  logic [RespCw-1:0] len_q, len_d;
  logic              ovf_q, ovf_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  in_item_t          item_q;
  logic [7:0]        b0_q, b0_d, b1_q, b1_d;
  logic [7:0]        rsp0_q, rsp0_d;
  logic [7:0]        hdr1_q, hdr1_d, hdr2_q, hdr2_d;

  logic              accept;
  logic              out_free;
  logic              push;
  out_item_t         res;
  logic [7:0]        b0_new, b1_new;
  logic [1:0]        lun;
  logic              ovf_new;
  logic [ReqCw-1:0]  run_nxt;

  assign in_stall_o  = (fsm_q != S_WAIT);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // request header bytes as they stand after this data word
  assign b0_new  = (cnt_q == '0) ? item_q.data_byte : b0_q;
  assign b1_new  = (cnt_q == ReqCw'(1)) ? item_q.data_byte : b1_q;
  assign lun     = b0_new[1:0] & LunMask;
  assign ovf_new = ovf_q || (len_q >= RespFull);
  assign run_nxt = run_q + ReqCw'(1);

  // next-state and result logic
  always_comb begin
    fsm_d        = fsm_q;
    ph_d         = ph_q;
    kst_d        = kst_q;
    err_d        = err_q;
    cnt_d        = cnt_q;
    run_d        = run_q;
    idx_d        = idx_q;
    len_d        = len_q;
    ovf_d        = ovf_q;
    b0_d         = b0_q;
    b1_d         = b1_q;
    rsp0_d       = rsp0_q;
    hdr1_d       = hdr1_q;
    hdr2_d       = hdr2_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    push         = 1'b0;
    res          = '0;
    req_we_o     = 1'b0;
    req_waddr_o  = cnt_q[ReqAw-1:0];
    req_wdata_o  = item_q.data_byte;
    req_re_o     = 1'b0;
    req_raddr_o  = '0;
    resp_we_o    = 1'b0;
    resp_waddr_o = len_q[RespAw-1:0];
    resp_wdata_o = item_q.data_byte;
    resp_re_o    = 1'b0;
    resp_raddr_o = idx_q[RespAw-1:0];

    unique case (fsm_q)
      S_WAIT: begin
        if (accept) begin
          fsm_d = S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          fsm_d         = S_WAIT;
          push          = 1'b1;
          res.last      = 1'b1;
          res.odr_valid = 1'b1;
          unique case (item_q.opcode)
            // host command word
            OpCmd: begin
              kst_d = KsWrite;
              if (item_q.data_byte == CcWstart) begin
                err_d = ErrNone;
                cnt_d = '0;
                idx_d = '0;
                len_d = '0;
                ph_d  = PH_WSTART;
              end else if (item_q.data_byte == CcWend) begin
                if (err_q != ErrNone) begin
                  kst_d = KsError;
                  ph_d  = PH_ERROR;
                  cnt_d = '0;
                end else begin
                  ph_d = PH_WEND;
                end
              end else if (item_q.data_byte == CcAbort) begin
                ph_d  = PH_ABORT1;
                err_d = ErrAborted;
              end else begin
                err_d = ErrIllegal;
                kst_d = KsError;
                ph_d  = PH_ERROR;
                cnt_d = '0;
              end
            end

            // host data word
            OpData: begin
              unique case (ph_q)
                PH_WSTART, PH_WDATA: begin
                  if (cnt_q >= ReqFull) begin
                    err_d = ErrLength;
                    kst_d = KsError;
                    ph_d  = PH_ERROR;
                    cnt_d = '0;
                  end else begin
                    ph_d     = PH_WDATA;
                    kst_d    = KsWrite;
                    req_we_o = 1'b1;
                    b0_d     = b0_new;
                    b1_d     = b1_new;
                    cnt_d    = cnt_q + ReqCw'(1);
                  end
                end
                PH_WEND: begin
                  if (cnt_q >= ReqFull) begin
                    err_d = ErrLength;
                    kst_d = KsError;
                    ph_d  = PH_ERROR;
                    cnt_d = '0;
                  end else begin
                    kst_d    = KsRead;
                    req_we_o = 1'b1;
                    b0_d     = b0_new;
                    b1_d     = b1_new;
                    cnt_d    = cnt_q + ReqCw'(1);
                    rsp0_d   = b0_new | NetfnRespBit;
                    hdr1_d   = (cnt_q != '0) ? b1_new : 8'h00;
                    fsm_d    = S_HDR1;
                    if (lun != 2'b00 || cnt_q == '0) begin
                      // self-built reply, start reading at once
                      hdr2_d       = (lun != 2'b00) ? CompBadLun : CompBadLen;
                      len_d        = RespCw'(3);
                      idx_d        = RespCw'(1);
                      ph_d         = PH_READ;
                      res.odr_byte = b0_new | NetfnRespBit;
                    end else begin
                      // hand the request to the handler
                      ph_d  = PH_RWAIT;
                      len_d = RespCw'(2);
                      ovf_d = 1'b0;
                      idx_d = '0;
                      run_d = '0;
                      push  = 1'b0;
                    end
                  end
                end
                PH_READ: begin
                  if (item_q.data_byte != CcRead) begin
                    kst_d = KsError;
                  end else if (idx_q >= len_q) begin
                    kst_d = KsIdle;
                    ph_d  = PH_IDLE;
                  end else begin
                    resp_re_o = 1'b1;
                    push      = 1'b0;
                    fsm_d     = S_RDOUT;
                  end
                end
                PH_ABORT1: begin
                  kst_d        = KsRead;
                  ph_d         = PH_ABORT2;
                  res.odr_byte = abort_status(err_q);
                end
                PH_ABORT2: begin
                  kst_d = KsIdle;
                  ph_d  = PH_IDLE;
                end
                default: begin
                  kst_d = KsError;
                  ph_d  = PH_ERROR;
                  cnt_d = '0;
                end
              endcase
            end

            // handler response word
            OpHandler: begin
              res.odr_valid = 1'b0;
              if (ph_q == PH_RWAIT) begin
                ovf_d = ovf_new;
                if (len_q < RespFull) begin
                  resp_we_o = 1'b1;
                  len_d     = len_q + RespCw'(1);
                end
                if (item_q.resp_last) begin
                  if (ovf_new) begin
                    resp_we_o    = 1'b1;
                    resp_waddr_o = RespCompSlot;
                    resp_wdata_o = CompOverflow;
                    len_d        = RespCw'(3);
                  end
                  ph_d          = PH_READ;
                  idx_d         = RespCw'(1);
                  res.odr_valid = 1'b1;
                  res.odr_byte  = rsp0_q;
                end
              end
            end

            default: begin
              res.odr_valid = 1'b0;
            end
          endcase
        end
      end

      // response command byte, then completion code or request run
      S_HDR1: begin
        resp_we_o    = 1'b1;
        resp_waddr_o = RespCmdSlot;
        resp_wdata_o = hdr1_q;
        if (ph_q == PH_READ) begin
          fsm_d = S_HDR2;
        end else begin
          req_re_o    = 1'b1;
          req_raddr_o = '0;
          fsm_d       = S_RUN;
        end
      end

      S_HDR2: begin
        resp_we_o    = 1'b1;
        resp_waddr_o = RespCompSlot;
        resp_wdata_o = hdr2_q;
        fsm_d        = S_WAIT;
      end

      // request bytes to the handler, one word per cycle while the output is not stalled
      S_RUN: begin
        if (out_free) begin
          push          = 1'b1;
          res.req_valid = 1'b1;
          res.req_byte  = req_rdata_i;
          if (run_nxt == cnt_q) begin
            res.last = 1'b1;
            fsm_d    = S_WAIT;
          end else begin
            run_d       = run_nxt;
            req_re_o    = 1'b1;
            req_raddr_o = run_nxt[ReqAw-1:0];
          end
        end
      end

      // next response byte for the host
      S_RDOUT: begin
        if (out_free) begin
          push          = 1'b1;
          res.odr_valid = 1'b1;
          res.odr_byte  = resp_rdata_i;
          res.last      = 1'b1;
          idx_d         = idx_q + RespCw'(1);
          fsm_d         = S_WAIT;
        end
      end

      default: begin
        fsm_d = S_WAIT;
      end
    endcase

    // result word carries the status after this step
    if (push) begin
      res.status_state = kst_d;
      res.error_code   = err_d;
      out_valid_d      = 1'b1;
      out_d            = res;
    end
  end

  // control state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= S_WAIT;
      ph_q        <= PH_IDLE;
      kst_q       <= KsIdle;
      err_q       <= ErrNone;
      cnt_q       <= '0;
      run_q       <= '0;
      idx_q       <= '0;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      fsm_q       <= fsm_d;
      ph_q        <= ph_d;
      kst_q       <= kst_d;
      err_q       <= err_d;
      cnt_q       <= cnt_d;
      run_q       <= run_d;
      idx_q       <= idx_d;
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    b0_q   <= b0_d;
    b1_q   <= b1_d;
    rsp0_q <= rsp0_d;
    hdr1_q <= hdr1_d;
    hdr2_q <= hdr2_d;
  end

endmodule

// File: src/ipmi_kcs_bmc_side_engine_top.sv
// kcs bmc-side engine: one word at a time; the word is registered and the first result
// is then registered from it. a write end with a self-built reply adds two header writes;
// one that hands a request on writes the command byte, then sends the request on, one
// request byte per cycle from the request ram while the output is not stalled; a response
// read goes through the response ram read port. output stalls can hold each of these steps.
// reset clears phase, status and counters; the buffer rams are not cleared.

module ipmi_kcs_bmc_side_engine_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ikcs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ikcs_pkg::out_item_t out_data_o
);

  import ikcs_pkg::*;

  logic              req_we, req_re, resp_we, resp_re;
  logic [ReqAw-1:0]  req_waddr, req_raddr;
  logic [RespAw-1:0] resp_waddr, resp_raddr;
  logic [7:0]        req_wdata, req_rdata, resp_wdata, resp_rdata;

  // protocol sequencer
  ikcs_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o),
    .req_we_o     (req_we),
    .req_waddr_o  (req_waddr),
    .req_wdata_o  (req_wdata),
    .req_re_o     (req_re),
    .req_raddr_o  (req_raddr),
    .req_rdata_i  (req_rdata),
    .resp_we_o    (resp_we),
    .resp_waddr_o (resp_waddr),
    .resp_wdata_o (resp_wdata),
    .resp_re_o    (resp_re),
    .resp_raddr_o (resp_raddr),
    .resp_rdata_i (resp_rdata)
  );

  // request buffer
  ikcs_ram #(
    .Depth (ReqDepth),
    .Width (8)
  ) u_req_ram (
    .clk_i   (clk_i),
    .we_i    (req_we),
    .waddr_i (req_waddr),
    .wdata_i (req_wdata),
    .re_i    (req_re),
    .raddr_i (req_raddr),
    .rdata_o (req_rdata)
  );

  // response buffer
  ikcs_ram #(
    .Depth (RespDepth),
    .Width (8)
  ) u_resp_ram (
    .clk_i   (clk_i),
    .we_i    (resp_we),
    .waddr_i (resp_waddr),
    .wdata_i (resp_wdata),
    .re_i    (resp_re),
    .raddr_i (resp_raddr),
    .rdata_o (resp_rdata)
  );

endmodule

// File: tb/sv/tb_ipmi_kcs_bmc_side_engine_top.sv
`timescale 1ns / 1ps
// testbench for the kcs bmc-side engine: directed then random host and handler words,
// every result word predicted by a protocol model of its own and checked in order
// depends on ikcs_pkg and ipmi_kcs_bmc_side_engine_top

module tb_ipmi_kcs_bmc_side_engine_top;
  import ikcs_pkg::*;

  localparam logic [1:0]  OpSpare      = 2'd3;
  localparam int unsigned RandWords    = 24;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned SettleCycles = 100;
  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned PrintCap     = 40;

  typedef enum logic [3:0] {
    PhIdle, PhWstart, PhWdata, PhWend, PhRwait, PhRead, PhAbort1, PhAbort2, PhError
  } kcs_phase_e;

  typedef enum logic [1:0] {StallNone, StallRandom, StallHeavy, StallToggle} stall_mode_e;

  // a queued host word, or a marker that makes the sender wait for all results
  typedef struct packed {
    logic     drain;
    in_item_t word;
  } host_word_t;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  host_word_t  words_to_send [$];
  out_item_t   results_due [$];
  host_word_t  next_word;
  int unsigned words_queued = 0;
  int unsigned words_taken  = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned gap_left     = 0;
  int unsigned burst_left   = 0;
  int unsigned hold_at      = 32'hFFFF_FFFF;
  int unsigned hold_left    = 0;
  logic        hold_done    = 1'b0;
  stall_mode_e stall_mode   = StallNone;
  int unsigned mode_left    = 0;

  // engine state as the protocol defines it
  kcs_phase_e  ph        = PhIdle;
  logic [1:0]  err_q     = ErrNone;
  logic [1:0]  kst_q     = KsIdle;
  logic [7:0]  req_mem  [ReqDepth];
  logic [7:0]  resp_mem [RespDepth];
  int unsigned req_cnt   = 0;
  int unsigned resp_idx  = 0;
  int unsigned resp_len  = 0;
  logic        resp_ovf  = 1'b0;

  ipmi_kcs_bmc_side_engine_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #10 clk_i = ~clk_i;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < PrintCap) begin
      $display("%0t result %0d, %s: got %0h want %0h", $time, results_seen, what, got, want);
    end
    mismatches++;
  endtask

  // expected result word, stamped with the status after the step
  function automatic void add_result(logic ov, logic [7:0] ob, logic rv, logic [7:0] rb,
                                     logic fin);
    out_item_t r;
    r.odr_valid    = ov;
    r.odr_byte     = ob;
    r.status_state = kst_q;
    r.error_code   = err_q;
    r.req_valid    = rv;
    r.req_byte     = rb;
    r.last         = fin;
    results_due.push_back(r);
  endfunction

  function automatic void abort_forced();
    kst_q   = KsError;
    ph      = PhError;
    req_cnt = 0;
    add_result(1'b1, 8'h00, 1'b0, 8'h00, 1'b1);
  endfunction

  function automatic void reply_first();
    ph       = PhRead;
    resp_idx = 1;
    add_result(1'b1, resp_mem[0], 1'b0, 8'h00, 1'b1);
  endfunction

  // one accepted word moves the engine on and yields its result words
  function automatic void advance_kcs(in_item_t w);
    logic [7:0]  b;
    logic [7:0]  b0;
    logic [7:0]  st_byte;
    int unsigned i;
    b = w.data_byte;
    st_byte = 8'h00;
    case (w.opcode)
      OpCmd: begin
        kst_q = KsWrite;
        if (b == CcWstart) begin
          err_q    = ErrNone;
          req_cnt  = 0;
          resp_idx = 0;
          resp_len = 0;
          ph       = PhWstart;
          add_result(1'b1, 8'h00, 1'b0, 8'h00, 1'b1);
        end else if (b == CcWend) begin
          if (err_q != ErrNone) begin
            abort_forced();
          end else begin
            ph = PhWend;
            add_result(1'b1, 8'h00, 1'b0, 8'h00, 1'b1);
          end
        end else if (b == CcAbort) begin
          ph    = PhAbort1;
          err_q = ErrAborted;
          add_result(1'b1, 8'h00, 1'b0, 8'h00, 1'b1);
        end else begin
          err_q = ErrIllegal;
          abort_forced();
        end
      end
      OpData: begin
        case (ph)
          PhWstart, PhWdata: begin
            ph = PhWdata;
            if (req_cnt >= ReqDepth) begin
              err_q = ErrLength;
              abort_forced();
            end else begin
              kst_q = KsWrite;
              req_mem[req_cnt] = b;
              req_cnt++;
              add_result(1'b1, 8'h00, 1'b0, 8'h00, 1'b1);
            end
          end
          PhWend: begin
            if (req_cnt >= ReqDepth) begin
              err_q = ErrLength;
              abort_forced();
            end else begin
              kst_q = KsRead;
              req_mem[req_cnt] = b;
              req_cnt++;
              ph = PhRwait;
              // response header: netfn turned into a response, then the command
              b0 = req_mem[0];
              resp_mem[0] = b0 | NetfnRespBit;
              resp_mem[1] = (req_cnt >= 2) ? req_mem[1] : 8'h00;
              if (b0[1:0] != 2'b00 || req_cnt < 2) begin
                resp_mem[2] = (b0[1:0] != 2'b00) ? CompBadLun : CompBadLen;
                resp_len = 3;
                reply_first();
              end else begin
                resp_len = 2;
                resp_ovf = 1'b0;
                resp_idx = 0;
                for (i = 0; i < req_cnt; i++) begin
                  add_result(1'b0, 8'h00, 1'b1, req_mem[i], i == req_cnt - 1);
                end
              end
            end
          end
          PhRead: begin
            if (resp_idx >= resp_len) kst_q = KsIdle;
            if (b != CcRead) begin
              kst_q = KsError;
              add_result(1'b1, 8'h00, 1'b0, 8'h00, 1'b1);
            end else if (resp_idx >= resp_len) begin
              ph = PhIdle;
              add_result(1'b1, 8'h00, 1'b0, 8'h00, 1'b1);
            end else begin
              add_result(1'b1, resp_mem[resp_idx], 1'b0, 8'h00, 1'b1);
              resp_idx++;
            end
          end
          PhAbort1: begin
            kst_q = KsRead;
            ph    = PhAbort2;
            case (err_q)
              ErrAborted: st_byte = 8'h01;
              ErrIllegal: st_byte = 8'h02;
              ErrLength:  st_byte = 8'h06;
              default:    st_byte = 8'h00;
            endcase
            add_result(1'b1, st_byte, 1'b0, 8'h00, 1'b1);
          end
          PhAbort2: begin
            kst_q = KsIdle;
            ph    = PhIdle;
            add_result(1'b1, 8'h00, 1'b0, 8'h00, 1'b1);
          end
          default: begin
            abort_forced();
          end
        endcase
      end
      OpHandler: begin
        if (ph != PhRwait) begin
          add_result(1'b0, 8'h00, 1'b0, 8'h00, 1'b1);
        end else begin
          if (resp_len < RespDepth) begin
            resp_mem[resp_len] = b;
            resp_len++;
          end else begin
            resp_ovf = 1'b1;
          end
          if (!w.resp_last) begin
            add_result(1'b0, 8'h00, 1'b0, 8'h00, 1'b1);
          end else begin
            // a response that did not fit collapses to a lone completion code
            if (resp_ovf) begin
              resp_mem[2] = CompOverflow;
              resp_len = 3;
            end
            reply_first();
          end
        end
      end
      default: begin
        add_result(1'b0, 8'h00, 1'b0, 8'h00, 1'b1);
      end
    endcase
  endfunction

  task automatic send(logic [1:0] op, logic [7:0] b, logic rl);
    host_word_t hw;
    hw.drain          = 1'b0;
    hw.word.opcode    = op;
    hw.word.data_byte = b;
    hw.word.resp_last = rl;
    words_to_send.push_back(hw);
    words_queued++;
  endtask

  task automatic hold_for_drain();
    host_word_t hw;
    hw = '0;
    hw.drain = 1'b1;
    words_to_send.push_back(hw);
  endtask

  // one host transfer: write phase, handler answer where one is due, then reads
  task automatic host_transaction(int unsigned n_req, int unsigned n_resp, logic lun_zero,
                                  logic skip_start);
    logic [7:0]  b0;
    int unsigned i;
    int unsigned reads;
    b0 = 8'($urandom_range(0, 255));
    if (lun_zero) b0[1:0] = 2'b00;
    if (!skip_start) send(OpCmd, CcWstart, 1'($urandom_range(0, 1)));
    for (i = 0; i + 1 < n_req; i++) begin
      send(OpData, (i == 0) ? b0 : 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    send(OpCmd, CcWend, 1'($urandom_range(0, 1)));
    send(OpData, (n_req == 1) ? b0 : 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    reads = 3;
    if (skip_start || (b0[1:0] == 2'b00 && n_req >= 2)) begin
      for (i = 0; i < n_resp; i++) begin
        send(OpHandler, 8'($urandom_range(0, 255)), i == n_resp - 1);
      end
      reads = (n_resp > RespDepth - 2) ? 3 : 2 + n_resp;
    end
    for (i = 0; i < reads; i++) begin
      // now and then a wrong control code in the read phase
      if ($urandom_range(0, 9) == 0) send(OpData, 8'($urandom_range(0, 255)), 1'b0);
      send(OpData, CcRead, 1'($urandom_range(0, 1)));
    end
  endtask

  // sender: bursts of words with random gaps, waits at drain markers
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid || !in_stall)) begin
      if (!in_valid && words_to_send.size() != 0 && words_to_send[0].drain &&
          results_due.size() == 0) begin
        next_word = words_to_send.pop_front();
      end
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (words_to_send.size() != 0 && !words_to_send[0].drain) begin
        next_word = words_to_send.pop_front();
        in_data  <= next_word.word;
        in_valid <= 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern changes now and then, one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && words_taken >= hold_at) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_e'($urandom_range(0, 3));
          mode_left  = $urandom_range(32, 200);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          StallNone:   out_stall <= 1'b0;
          StallRandom: out_stall <= 1'($urandom_range(0, 1));
          StallHeavy:  out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // monitor: predict on each accepted word, check each accepted result
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        advance_kcs(in_data);
        words_taken++;
      end
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch("result word with none due", 32'(out_data), 32'd0);
        end else begin
          want = results_due.pop_front();
          if (out_data.odr_valid !== want.odr_valid)
            report_mismatch("odr_valid", 32'(out_data.odr_valid), 32'(want.odr_valid));
          if (out_data.odr_byte !== want.odr_byte)
            report_mismatch("odr_byte", 32'(out_data.odr_byte), 32'(want.odr_byte));
          if (out_data.status_state !== want.status_state)
            report_mismatch("status_state", 32'(out_data.status_state),
                            32'(want.status_state));
          if (out_data.error_code !== want.error_code)
            report_mismatch("error_code", 32'(out_data.error_code), 32'(want.error_code));
          if (out_data.req_valid !== want.req_valid)
            report_mismatch("req_valid", 32'(out_data.req_valid), 32'(want.req_valid));
          if (out_data.req_byte !== want.req_byte)
            report_mismatch("req_byte", 32'(out_data.req_byte), 32'(want.req_byte));
          if (out_data.last !== want.last)
            report_mismatch("last", 32'(out_data.last), 32'(want.last));
        end
        results_seen++;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("no progress, stopped after %0d cycles", cycle_cnt);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned goal;
    int unsigned pick;
    int unsigned n;
    logic [7:0]  nb;

    // data byte while idle, illegal control code, write end with an error pending
    send(OpData, 8'hFF, 1'b1);
    send(OpCmd, 8'h00, 1'b0);
    send(OpCmd, CcWend, 1'b1);
    // abort by command and its two status reads
    send(OpCmd, CcAbort, 1'b0);
    send(OpData, 8'h00, 1'b0);
    send(OpData, 8'h5A, 1'b1);
    // spare opcode and a handler byte nobody waits for
    send(OpSpare, 8'hA5, 1'b1);
    send(OpHandler, 8'h3C, 1'b1);
    // non-zero lun gets its own reply, one wrong control code while reading
    send(OpCmd, CcWstart, 1'b0);
    send(OpData, 8'h1F, 1'b0);
    send(OpCmd, CcWend, 1'b0);
    send(OpData, 8'h00, 1'b0);
    send(OpData, CcRead, 1'b0);
    send(OpData, 8'hFF, 1'b0);
    send(OpData, CcRead, 1'b0);
    send(OpData, CcRead, 1'b0);
    // one-byte request gets the bad length reply
    send(OpCmd, CcWstart, 1'b1);
    send(OpCmd, CcWend, 1'b0);
    send(OpData, 8'h18, 1'b0);
    // request handed on, two handler bytes, then read out
    send(OpCmd, CcWstart, 1'b0);
    send(OpData, 8'h18, 1'b0);
    send(OpCmd, CcWend, 1'b0);
    send(OpData, 8'h01, 1'b1);
    send(OpHandler, 8'hC0, 1'b0);
    send(OpHandler, 8'h00, 1'b1);
    repeat (4) send(OpData, CcRead, 1'b0);
    hold_for_drain();

    // random part: mostly well-formed transfers, some aborts and noise
    goal = words_queued + RandWords;
    while (words_queued < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        host_transaction($urandom_range(1, 6), $urandom_range(1, 5),
                         $urandom_range(0, 4) != 0, 1'b0);
      end else if (pick < 68) begin
        // write end with no write start carries on the kept request
        host_transaction(1, $urandom_range(1, 3), 1'b1, 1'b1);
      end else if (pick < 78) begin
        send(OpCmd, CcAbort, 1'($urandom_range(0, 1)));
        send(OpData, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        send(OpData, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (pick < 95) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          case ($urandom_range(0, 5))
            0:       nb = CcAbort;
            1:       nb = CcWstart;
            2:       nb = CcWend;
            3:       nb = CcRead;
            default: nb = 8'($urandom_range(0, 255));
          endcase
          send(2'($urandom_range(0, 3)), nb, 1'($urandom_range(0, 1)));
        end
      end else begin
        hold_for_drain();
      end
    end

    // full request run with an overflowing answer; the receiver holds off meanwhile
    hold_for_drain();
    hold_at = words_queued;
    host_transaction(ReqDepth, RespDepth - 1, 1'b1, 1'b0);
    // write end on the full request buffer gives a length error
    send(OpCmd, CcWend, 1'b0);
    send(OpData, 8'($urandom_range(0, 255)), 1'b0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_to_send.size() != 0 || in_valid || results_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (results_due.size() != 0) begin
      report_mismatch("results never seen", 32'(results_due.size()), 32'd0);
    end
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
